/* hw/rtl/i2c_master_transaction_sequencer_macros.svh */
// Assertion macros shared by the I2C transaction sequencer checkers.
// Needs clk_i and rst_ni visible in the scope where a macro is used.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define I2CSEQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("i2c sequencer check failed");

// Expression must never be true outside reset.
`define I2CSEQ_NEVER(lbl, expr) \
  `I2CSEQ_ASSERT(lbl, !(expr))

`endif

/* hw/rtl/i2cseq_pkg.sv */
// Types and constants of the I2C master transaction sequencer.
// No dependencies; used by the step logic, the top level and the checker.
`default_nettype none

package i2cseq_pkg;

  typedef enum logic [1:0] {
    OP_BEGIN_WR    = 2'd0,
    OP_BEGIN_RD    = 2'd1,
    OP_BEGIN_WR_RD = 2'd2,
    OP_BUS_DONE    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_RACK  = 3'd3,
    CMD_RNACK = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_e;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_START   = 8'b0000_0010,
    PH_SLA_W   = 8'b0000_0100,
    PH_DATA_W  = 8'b0000_1000,
    PH_RESTART = 8'b0001_0000,
    PH_SLA_R   = 8'b0010_0000,
    PH_DATA_RA = 8'b0100_0000,
    PH_DATA_RN = 8'b1000_0000
  } phase_e;

  localparam logic [7:0] STATUS_MASK  = 8'hF8;
  localparam logic [7:0] CODE_START   = 8'h08;
  localparam logic [7:0] CODE_RESTART = 8'h10;
  localparam logic [7:0] CODE_SLA_W   = 8'h18;
  localparam logic [7:0] CODE_DATA_W  = 8'h28;
  localparam logic [7:0] CODE_SLA_R   = 8'h40;
  localparam logic [7:0] CODE_DATA_RA = 8'h50;
  localparam logic [7:0] CODE_DATA_RN = 8'h58;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] kind;
    logic [6:0] addr;
    logic [7:0] writes_left;
    logic [7:0] reads_left;
  } seq_state_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] cmd_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic       finished;
    logic       failed;
  } seq_result_t;

  // Status code the engine must report to move on from a phase.
  function automatic logic [7:0] expected_status(phase_e ph);
    logic [7:0] code;
    code = 8'h00;
    case (ph)
      PH_START:   code = CODE_START;
      PH_SLA_W:   code = CODE_SLA_W;
      PH_DATA_W:  code = CODE_DATA_W;
      PH_RESTART: code = CODE_RESTART;
      PH_SLA_R:   code = CODE_SLA_R;
      PH_DATA_RA: code = CODE_DATA_RA;
      PH_DATA_RN: code = CODE_DATA_RN;
      default:    code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/i2cseq_step.sv */
// Next-state and command logic for one transaction of the sequencer.
// Depends on i2cseq_pkg.
`default_nettype none

module i2cseq_step
  import i2cseq_pkg::*;
(
  input  seq_state_t  state_i,
  input  logic [1:0]  opcode_i,
  input  logic [6:0]  slave_address_i,
  input  logic [7:0]  write_count_i,
  input  logic [7:0]  read_count_i,
  input  logic [7:0]  bus_status_i,
  input  logic [7:0]  received_byte_i,
  input  logic [7:0]  next_tx_byte_i,
  output seq_state_t  state_o,
  output seq_result_t result_o
);

  logic [7:0] status_masked;

  assign status_masked = bus_status_i & STATUS_MASK;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.cmd = CMD_NONE;

    if (opcode_i != OP_BUS_DONE) begin
      // A begin while a transfer runs is dropped.
      if (state_i.phase == PH_IDLE) begin
        state_o.kind        = opcode_i;
        state_o.addr        = slave_address_i;
        state_o.writes_left = write_count_i;
        state_o.reads_left  = (read_count_i == 8'd0) ? 8'd1 : read_count_i;
        state_o.phase       = PH_START;
        result_o.cmd        = CMD_START;
      end
    end else if (state_i.phase != PH_IDLE) begin
      if (status_masked != expected_status(state_i.phase)) begin
        result_o.cmd    = CMD_STOP;
        result_o.failed = 1'b1;
        state_o.phase   = PH_IDLE;
      end else begin
        case (state_i.phase)
          PH_START: begin
            result_o.cmd = CMD_SEND;
            if (state_i.kind == OP_BEGIN_RD) begin
              result_o.cmd_byte = {state_i.addr, 1'b1};
              state_o.phase     = PH_SLA_R;
            end else begin
              result_o.cmd_byte = {state_i.addr, 1'b0};
              state_o.phase     = PH_SLA_W;
            end
          end
          PH_SLA_W, PH_DATA_W: begin
            if (state_i.writes_left != 8'd0) begin
              result_o.cmd        = CMD_SEND;
              result_o.cmd_byte   = next_tx_byte_i;
              state_o.writes_left = state_i.writes_left - 8'd1;
              state_o.phase       = PH_DATA_W;
            end else if (state_i.kind == OP_BEGIN_WR_RD) begin
              result_o.cmd  = CMD_START;
              state_o.phase = PH_RESTART;
            end else begin
              result_o.cmd      = CMD_STOP;
              result_o.finished = 1'b1;
              state_o.phase     = PH_IDLE;
            end
          end
          PH_RESTART: begin
            result_o.cmd      = CMD_SEND;
            result_o.cmd_byte = {state_i.addr, 1'b1};
            state_o.phase     = PH_SLA_R;
          end
          PH_SLA_R, PH_DATA_RA: begin
            if (state_i.phase == PH_DATA_RA) begin
              result_o.read_valid = 1'b1;
              result_o.read_data  = received_byte_i;
            end
            // Ack every byte but the last.
            if (state_i.reads_left > 8'd1) begin
              result_o.cmd  = CMD_RACK;
              state_o.phase = PH_DATA_RA;
            end else begin
              result_o.cmd  = CMD_RNACK;
              state_o.phase = PH_DATA_RN;
            end
            if (state_i.reads_left != 8'd0) begin
              state_o.reads_left = state_i.reads_left - 8'd1;
            end
          end
          PH_DATA_RN: begin
            result_o.read_valid = 1'b1;
            result_o.read_data  = received_byte_i;
            result_o.cmd        = CMD_STOP;
            result_o.finished   = 1'b1;
            state_o.phase       = PH_IDLE;
          end
          default: begin
            state_o.phase = PH_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/i2c_master_transaction_sequencer.sv */
// I2C master transaction sequencer: one command per incoming transaction.
// Channels: input transaction on in_valid_i/in_ready_o with opcode and bus
// fields; result on out_valid_o/out_ready_i with command, byte and flags.
// A begin transaction (write, read, write then read) in idle latches the address
// and counts and answers with a start. Each bus-done transaction outside idle is
// checked against the status expected in the current phase and answered with the
// next bus command, or with a stop and failed on a mismatch; others get no command.
// Every input transaction yields exactly one result, in the cycle after it is
// accepted; one transaction per cycle is sustained while the receiver takes each
// result, set by the single result register behind the step logic.
// Reset puts the block idle with no result pending.
// When the receiver stalls, the held result stays on the output and the
// input is still taken in the cycle the result is taken.
// Depends on i2cseq_pkg and i2cseq_step.
`default_nettype none

module i2c_master_transaction_sequencer
  import i2cseq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [6:0] slave_address_i,
  input  logic [7:0] write_count_i,
  input  logic [7:0] read_count_i,
  input  logic [7:0] bus_status_i,
  input  logic [7:0] received_byte_i,
  input  logic [7:0] next_tx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] bus_command_o,
  output logic [7:0] command_byte_o,
  output logic       read_valid_o,
  output logic [7:0] read_data_o,
  output logic       finished_o,
  output logic       failed_o
);

  seq_state_t  state_q, state_d;
  seq_result_t res_q, res_d;
  logic        out_valid_q;
  logic        accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  i2cseq_step u_step (
    .state_i         (state_q),
    .opcode_i        (opcode_i),
    .slave_address_i (slave_address_i),
    .write_count_i   (write_count_i),
    .read_count_i    (read_count_i),
    .bus_status_i    (bus_status_i),
    .received_byte_i (received_byte_i),
    .next_tx_byte_i  (next_tx_byte_i),
    .state_o         (state_d),
    .result_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PH_IDLE, kind: 2'd0, addr: 7'd0,
                       writes_left: 8'd0, reads_left: 8'd0};
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bus_command_o  = res_q.cmd;
  assign command_byte_o = res_q.cmd_byte;
  assign read_valid_o   = res_q.read_valid;
  assign read_data_o    = res_q.read_data;
  assign finished_o     = res_q.finished;
  assign failed_o       = res_q.failed;

endmodule

`default_nettype wire

/* hw/rtl/i2cseq_checker.sv */
// Port-level checks for the I2C master transaction sequencer, bound to it.
// Depends on i2cseq_pkg and i2c_master_transaction_sequencer_macros.svh.
`default_nettype none

`include "i2c_master_transaction_sequencer_macros.svh"

module i2cseq_checker
  import i2cseq_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [2:0] bus_command_o,
  input wire logic [7:0] command_byte_o,
  input wire logic       read_valid_o,
  input wire logic       finished_o,
  input wire logic       failed_o
);

  `I2CSEQ_ASSERT(a_result_follows, in_valid_i && in_ready_o |=> out_valid_o)
  `I2CSEQ_ASSERT(a_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(bus_command_o))
  `I2CSEQ_NEVER(a_end_flags, out_valid_o && (finished_o || failed_o) && bus_command_o != CMD_STOP)
  `I2CSEQ_NEVER(a_send_byte, out_valid_o && bus_command_o != CMD_SEND && command_byte_o != 8'h00)
  `I2CSEQ_NEVER(a_read_no_fail, out_valid_o && read_valid_o && failed_o)

endmodule

bind i2c_master_transaction_sequencer i2cseq_checker u_i2cseq_checker (.*);

`default_nettype wire

/* bench/tb_i2c_master_transaction_sequencer.sv */
// Self-checking bench for i2c_master_transaction_sequencer: directed table, then random
// transfers, each result checked against its table row or an in-bench sequencer model.
// Depends on i2cseq_pkg and the sequencer RTL.
`timescale 1ns / 100ps

module tb_i2c_master_transaction_sequencer;
  import i2cseq_pkg::*;

  localparam int RANDOM_TXNS = 1525;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    opcode_e    op;
    logic [6:0] addr;
    logic [7:0] wcnt;
    logic [7:0] rcnt;
    logic [7:0] status;
    logic [7:0] rx;
    logic [7:0] tx;
  } txn_t;

  typedef struct packed {
    txn_t        t;
    logic        fixed;
    seq_result_t want;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] opcode_i = '0;
  logic [6:0] slave_address_i = '0;
  logic [7:0] write_count_i = '0;
  logic [7:0] read_count_i = '0;
  logic [7:0] bus_status_i = '0;
  logic [7:0] received_byte_i = '0;
  logic [7:0] next_tx_byte_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] bus_command_o;
  logic [7:0] command_byte_o;
  logic       read_valid_o;
  logic [7:0] read_data_o;
  logic       finished_o;
  logic       failed_o;

  i2c_master_transaction_sequencer dut (.*);

  always #4 clk_i = ~clk_i;

  // Model state of the sequencer
  phase_e     bus_phase = PH_IDLE;
  opcode_e    xfer_kind = OP_BEGIN_WR;
  logic [6:0] xfer_addr = '0;
  logic [7:0] tx_remaining = '0;
  logic [7:0] rx_remaining = '0;

  seq_result_t pending_cmds[$];
  dir_row_t    dir_rows[$];
  txn_t        cur_txn = '0;
  logic        cur_fixed = 1'b0;
  seq_result_t cur_want = '0;
  int          src_idle_pct = 13;
  int          sink_idle_pct = 68;
  int          fail_count = 0;
  int          stall_cycles = 0;
  bit          moved = 1'b0;

  function automatic logic [7:0] status_for(input phase_e ph);
    case (ph)
      PH_START:   return CODE_START;
      PH_SLA_W:   return CODE_SLA_W;
      PH_DATA_W:  return CODE_DATA_W;
      PH_RESTART: return CODE_RESTART;
      PH_SLA_R:   return CODE_SLA_R;
      PH_DATA_RA: return CODE_DATA_RA;
      PH_DATA_RN: return CODE_DATA_RN;
      default:    return 8'h00;
    endcase
  endfunction

  // Ack every byte but the last one
  function automatic cmd_e next_read_cmd();
    cmd_e c;
    if (rx_remaining > 8'd1) begin
      c = CMD_RACK;
      bus_phase = PH_DATA_RA;
    end else begin
      c = CMD_RNACK;
      bus_phase = PH_DATA_RN;
    end
    if (rx_remaining != 8'd0) rx_remaining = rx_remaining - 8'd1;
    return c;
  endfunction

  function automatic seq_result_t predict_command(input txn_t t);
    seq_result_t r;
    r = '0;
    if (t.op != OP_BUS_DONE) begin
      if (bus_phase == PH_IDLE) begin
        xfer_kind = t.op;
        xfer_addr = t.addr;
        tx_remaining = t.wcnt;
        rx_remaining = (t.rcnt == 8'd0) ? 8'd1 : t.rcnt;
        r.cmd = CMD_START;
        bus_phase = PH_START;
      end
    end else if (bus_phase != PH_IDLE) begin
      if ((t.status & STATUS_MASK) != status_for(bus_phase)) begin
        r.cmd = CMD_STOP;
        r.failed = 1'b1;
        bus_phase = PH_IDLE;
      end else begin
        case (bus_phase)
          PH_START: begin
            r.cmd = CMD_SEND;
            if (xfer_kind == OP_BEGIN_RD) begin
              r.cmd_byte = {xfer_addr, 1'b1};
              bus_phase = PH_SLA_R;
            end else begin
              r.cmd_byte = {xfer_addr, 1'b0};
              bus_phase = PH_SLA_W;
            end
          end
          PH_SLA_W, PH_DATA_W: begin
            if (tx_remaining != 8'd0) begin
              r.cmd = CMD_SEND;
              r.cmd_byte = t.tx;
              tx_remaining = tx_remaining - 8'd1;
              bus_phase = PH_DATA_W;
            end else if (xfer_kind == OP_BEGIN_WR_RD) begin
              r.cmd = CMD_START;
              bus_phase = PH_RESTART;
            end else begin
              r.cmd = CMD_STOP;
              r.finished = 1'b1;
              bus_phase = PH_IDLE;
            end
          end
          PH_RESTART: begin
            r.cmd = CMD_SEND;
            r.cmd_byte = {xfer_addr, 1'b1};
            bus_phase = PH_SLA_R;
          end
          PH_SLA_R: r.cmd = next_read_cmd();
          PH_DATA_RA: begin
            r.read_valid = 1'b1;
            r.read_data = t.rx;
            r.cmd = next_read_cmd();
          end
          default: begin
            r.read_valid = 1'b1;
            r.read_data = t.rx;
            r.cmd = CMD_STOP;
            r.finished = 1'b1;
            bus_phase = PH_IDLE;
          end
        endcase
      end
    end
    return r;
  endfunction

  function automatic dir_row_t mk_row(input opcode_e op, input logic [6:0] addr,
                                      input logic [7:0] wcnt, input logic [7:0] rcnt,
                                      input logic [7:0] st, input logic [7:0] rx,
                                      input logic [7:0] tx, input logic fixed,
                                      input cmd_e cmd, input logic [7:0] cb,
                                      input logic rv, input logic [7:0] rd,
                                      input logic fin, input logic fl);
    dir_row_t row;
    row.t = '{op, addr, wcnt, rcnt, st, rx, tx};
    row.fixed = fixed;
    row.want = '{cmd, cb, rv, rd, fin, fl};
    return row;
  endfunction

  task automatic check_field(input string name, input int unsigned exp,
                             input int unsigned act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      fail_count++;
    end
  endtask

  // Hold the transaction on the port until it is taken
  task automatic send_txn(input txn_t t, input logic fixed, input seq_result_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= t.op;
    slave_address_i <= t.addr;
    write_count_i <= t.wcnt;
    read_count_i <= t.rcnt;
    bus_status_i <= t.status;
    received_byte_i <= t.rx;
    next_tx_byte_i <= t.tx;
    cur_txn <= t;
    cur_fixed <= fixed;
    cur_want <= want;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= sink_idle_pct);

  // Sample both channels mid-cycle, where every signal is settled
  always @(negedge clk_i) begin : monitor
    seq_result_t want;
    seq_result_t got;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want = predict_command(cur_txn);
        if (cur_fixed) want = cur_want;
        pending_cmds.push_back(want);
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (pending_cmds.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual cmd %0d byte %0h",
                   $time, bus_command_o, command_byte_o);
          fail_count++;
        end else begin
          want = pending_cmds.pop_front();
          got = '{cmd_e'(bus_command_o), command_byte_o, read_valid_o, read_data_o,
                  finished_o, failed_o};
          check_field("bus_command", 32'(want.cmd), 32'(got.cmd));
          check_field("command_byte", 32'(want.cmd_byte), 32'(got.cmd_byte));
          check_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
          check_field("read_data", 32'(want.read_data), 32'(got.read_data));
          check_field("finished", 32'(want.finished), 32'(got.finished));
          check_field("failed", 32'(want.failed), 32'(got.failed));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (moved) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_cmds.size());
        $display("CHECK FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    txn_t t;
    int   useful;
    int   dice;
    int   size;
    bit   ignored;

    // idle bus-done, begin while busy, extreme addresses and bytes
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00,
                              1, CMD_NONE,  8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BEGIN_WR,    7'h7F, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                              1, CMD_START, 8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BEGIN_RD,    7'h12, 8'h05, 8'h05, 8'h08, 8'h00, 8'h00,
                              1, CMD_NONE,  8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h0F, 8'h00, 8'h00,
                              1, CMD_SEND,  8'hFE, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h18, 8'h00, 8'hFF,
                              1, CMD_SEND,  8'hFF, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h28, 8'h00, 8'h00,
                              1, CMD_STOP,  8'h00, 0, 8'h00, 1, 0));
    // zero read count reads one byte
    dir_rows.push_back(mk_row(OP_BEGIN_RD,    7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                              1, CMD_START, 8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00,
                              1, CMD_SEND,  8'h01, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h47, 8'h00, 8'h00,
                              1, CMD_RNACK, 8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h58, 8'hFF, 8'h00,
                              1, CMD_STOP,  8'h00, 1, 8'hFF, 1, 0));
    // zero write count goes straight to the repeated start
    dir_rows.push_back(mk_row(OP_BEGIN_WR_RD, 7'h55, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00,
                              1, CMD_START, 8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00,
                              1, CMD_SEND,  8'hAA, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h18, 8'h00, 8'h00,
                              1, CMD_START, 8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00,
                              1, CMD_SEND,  8'hAB, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00,
                              1, CMD_RACK,  8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h50, 8'h00, 8'h00,
                              1, CMD_RNACK, 8'h00, 1, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h5F, 8'hA5, 8'h00,
                              1, CMD_STOP,  8'h00, 1, 8'hA5, 1, 0));
    // status mismatch: abort, received byte dropped
    dir_rows.push_back(mk_row(OP_BEGIN_WR,    7'h2A, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                              1, CMD_START, 8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00,
                              1, CMD_SEND,  8'h54, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h20, 8'hC3, 8'h00,
                              1, CMD_STOP,  8'h00, 0, 8'h00, 0, 1));
    dir_rows.push_back(mk_row(OP_BEGIN_RD,    7'h13, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00,
                              0, CMD_NONE,  8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00,
                              0, CMD_NONE,  8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00,
                              0, CMD_NONE,  8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h50, 8'h3C, 8'h00,
                              0, CMD_NONE,  8'h00, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_BUS_DONE,    7'h00, 8'h00, 8'h00, 8'h58, 8'h99, 8'h00,
                              1, CMD_STOP,  8'h00, 0, 8'h00, 0, 1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_txn(dir_rows[i].t, dir_rows[i].fixed, dir_rows[i].want);

    useful = 0;
    while (useful < RANDOM_TXNS) begin
      if (useful == RANDOM_TXNS / 3) begin
        src_idle_pct = 68;
        sink_idle_pct = 13;
      end else if (useful == 2 * RANDOM_TXNS / 3) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      t.op = opcode_e'($urandom_range(0, 3));
      t.addr = 7'($urandom_range(0, 127));
      t.wcnt = 8'($urandom_range(0, 255));
      t.rcnt = 8'($urandom_range(0, 255));
      t.status = 8'($urandom_range(0, 255));
      t.rx = 8'($urandom_range(0, 255));
      t.tx = 8'($urandom_range(0, 255));
      dice = $urandom_range(0, 99);
      if (bus_phase == PH_IDLE) begin
        if (dice < 92) begin
          t.op = opcode_e'($urandom_range(0, 2));
          size = $urandom_range(0, 99);
          // keep most transfers short; full-range counts only now and then
          if (size < 90) begin
            t.wcnt = 8'($urandom_range(0, 3));
            t.rcnt = 8'($urandom_range(0, 3));
          end else if (size < 99) begin
            t.wcnt = 8'($urandom_range(0, 20));
            t.rcnt = 8'($urandom_range(0, 20));
          end
        end else begin
          t.op = OP_BUS_DONE;
        end
      end else if (dice < 91) begin
        t.op = OP_BUS_DONE;
        t.status = status_for(bus_phase) | 8'($urandom_range(0, 7));
      end else if (dice < 96) begin
        t.op = OP_BUS_DONE;
      end
      ignored = (bus_phase == PH_IDLE) ? (t.op == OP_BUS_DONE) : (t.op != OP_BUS_DONE);
      send_txn(t, 1'b0, '0);
      if (!ignored) useful++;
    end
    in_valid_i <= 1'b0;

    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
